@@ rtl/ndtp_pkg.sv @@
// ----------------------------------------------------------------------------
// ndtp_pkg - numeric date text parser package
// Shared widths, codes, parse phases and the record passed from the
// character front end to the date builder.
// ----------------------------------------------------------------------------
package ndtp_pkg;

  // field widths
  localparam int CHAR_W     = 8;
  localparam int NUM_W      = 15;
  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_W     = 14;
  localparam int DATE_W     = 32;
  localparam int ORDER_W    = 2;
  localparam int PIVOT_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // number accumulation saturates here
  localparam logic [NUM_W-1:0] NUM_SAT = 15'd32767;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_ORDER   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTURY_PIVOT = 1'b1;

  // field order codes
  localparam logic [ORDER_W-1:0] ORD_DMY = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_MDY = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_YMD = 2'd2;

  // reset values of the configuration
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORD_DMY;
  localparam logic [PIVOT_W-1:0] PIVOT_RESET = 7'd50;

  // year handling
  localparam logic [NUM_W-1:0] TWO_DIGIT_LIMIT = 15'd100;
  localparam logic [NUM_W-1:0] CENTURY_19     = 15'd1900;
  localparam logic [NUM_W-1:0] CENTURY_20     = 15'd2000;
  localparam logic [NUM_W-1:0] DAY_MAX        = 15'd31;
  localparam logic [NUM_W-1:0] MONTH_MAX      = 15'd12;

  // year / 100 by reciprocal: (year * 5243) >> 19, exact for 14-bit years
  localparam int               DIV100_MUL_W = 13;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int               DIV100_SHIFT = 19;
  localparam int               PROD_W       = YEAR_W + DIV100_MUL_W;
  localparam int               QUOT_W       = PROD_W - DIV100_SHIFT;

  // record queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // parse phases
  typedef enum logic [2:0] {
    PH_START1,
    PH_IN1,
    PH_START2,
    PH_IN2,
    PH_START3,
    PH_IN3,
    PH_DONE
  } phase_t;

  // one finished string: parse status and the three numbers
  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] n1;
    logic [NUM_W-1:0] n2;
    logic [NUM_W-1:0] n3;
  } rec_t;

endpackage

@@ rtl/numeric_date_text_parser.sv @@
// Throughput: one character per cycle; the input stalls only while the record
// queue is full because the result channel is holding back.
// Path: after the last character is taken, its result passes through the queue,
// field select, year / 100 product, and leap test and packing registers to out_*.
// Reset: field order day-month-year, century pivot 50, parser cleared.
// ----------------------------------------------------------------------------
// numeric_date_text_parser - top level
// Parses a numeric date string into a packed 32-bit date with a valid flag;
// holds the field order and century pivot configuration registers.
// ----------------------------------------------------------------------------
module numeric_date_text_parser
  import ndtp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input characters
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_character,
  input  logic                  in_last_char,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_date_valid,
  output logic [DATE_W-1:0]     out_packed_date,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ORDER_W-1:0] field_order_r;
  logic [PIVOT_W-1:0] century_pivot_r;
  logic               push, q_full, head_valid, pop;
  rec_t               push_rec, head;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_order_r   <= ORDER_RESET;
      century_pivot_r <= PIVOT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIELD_ORDER:   field_order_r   <= cfg_data[ORDER_W-1:0];
        CFG_CENTURY_PIVOT: century_pivot_r <= cfg_data[PIVOT_W-1:0];
        default: ;
      endcase
    end
  end

  // character front end
  ndtp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .push         (push),
    .push_rec     (push_rec)
  );

  // record queue
  ndtp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // date builder
  ndtp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_valid       (head_valid),
    .rec             (head),
    .rec_pop         (pop),
    .field_order     (field_order_r),
    .century_pivot   (century_pivot_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_date_valid  (out_date_valid),
    .out_packed_date (out_packed_date)
  );

endmodule

@@ rtl/ndtp_front.sv @@
// ----------------------------------------------------------------------------
// ndtp_front - character classifier and number collector
// Takes one byte per cycle while the queue is not full, tracks the parse phase and
// accumulates the three numbers; on the last byte it pushes a record into the queue and clears.
// ----------------------------------------------------------------------------
module ndtp_front
  import ndtp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_character,
  input  logic              in_last_char,
  input  logic              q_full,
  output logic              push,
  output rec_t              push_rec
);

  phase_t           phase_r, phase_nxt;
  logic [NUM_W-1:0] n1_r, n1_nxt;
  logic [NUM_W-1:0] n2_r, n2_nxt;
  logic [NUM_W-1:0] n3_r, n3_nxt;
  logic             failed_r, failed_nxt;
  logic             accepted;
  logic             is_digit;
  logic [3:0]       digit;

  // multiply by ten and add, saturating
  function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0]       d);
    logic [NUM_W+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, d};
    acc_digit = (v > (NUM_W+4)'(NUM_SAT)) ? NUM_SAT : v[NUM_W-1:0];
  endfunction

  // stall only when the queue cannot take a record
  assign in_stall = q_full;
  assign accepted = in_valid && !q_full;
  assign is_digit = in_character inside {[8'h30:8'h39]};
  assign digit    = in_character[3:0];

  // phase and number registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START1;
      n1_r     <= '0;
      n2_r     <= '0;
      n3_r     <= '0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      n1_r     <= n1_nxt;
      n2_r     <= n2_nxt;
      n3_r     <= n3_nxt;
      failed_r <= failed_nxt;
    end
  end

  // next phase, numbers and the record for the last byte
  always_comb begin
    phase_t           ph_upd;
    logic [NUM_W-1:0] n1_upd, n2_upd, n3_upd;
    logic             fail_upd;
    ph_upd   = phase_r;
    n1_upd   = n1_r;
    n2_upd   = n2_r;
    n3_upd   = n3_r;
    fail_upd = failed_r;
    if (accepted && !failed_r) begin
      case (phase_r)
        PH_START1: begin
          if (is_digit) begin
            n1_upd = NUM_W'(digit);
            ph_upd = PH_IN1;
          end else begin
            fail_upd = 1'b1;
          end
        end
        PH_IN1: begin
          if (is_digit) n1_upd = acc_digit(n1_r, digit);
          else          ph_upd = PH_START2;
        end
        PH_START2: begin
          if (is_digit) begin
            n2_upd = NUM_W'(digit);
            ph_upd = PH_IN2;
          end else begin
            fail_upd = 1'b1;
          end
        end
        PH_IN2: begin
          if (is_digit) n2_upd = acc_digit(n2_r, digit);
          else          ph_upd = PH_START3;
        end
        PH_START3: begin
          if (is_digit) begin
            n3_upd = NUM_W'(digit);
            ph_upd = PH_IN3;
          end else begin
            ph_upd = PH_DONE;
          end
        end
        PH_IN3: begin
          if (is_digit) n3_upd = acc_digit(n3_r, digit);
          else          ph_upd = PH_DONE;
        end
        default: ph_upd = PH_DONE;
      endcase
    end

    // record of the finished string
    push        = accepted && in_last_char;
    push_rec.ok = !fail_upd &&
                  (ph_upd == PH_START3 || ph_upd == PH_IN3 || ph_upd == PH_DONE);
    push_rec.n1 = n1_upd;
    push_rec.n2 = n2_upd;
    push_rec.n3 = n3_upd;

    // clear after the last byte
    if (push) begin
      phase_nxt  = PH_START1;
      n1_nxt     = '0;
      n2_nxt     = '0;
      n3_nxt     = '0;
      failed_nxt = 1'b0;
    end else begin
      phase_nxt  = ph_upd;
      n1_nxt     = n1_upd;
      n2_nxt     = n2_upd;
      n3_nxt     = n3_upd;
      failed_nxt = fail_upd;
    end
  end

  // a finished string leaves the parser cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (phase_r == PH_START1) && !failed_r && (n1_r == '0) && (n2_r == '0)
             && (n3_r == '0))
    else $error("parser not cleared after last byte");

endmodule

@@ rtl/ndtp_queue.sv @@
// ----------------------------------------------------------------------------
// ndtp_queue - record queue between front end and date builder
// Small register queue so the parser keeps taking bytes while the builder
// or the result channel is stalled.
// ----------------------------------------------------------------------------
module ndtp_queue
  import ndtp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output rec_t head
);

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  // fill count stays consistent with the pointers
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= QCNT_W'(QDEPTH)) &&
    ((cnt_r == QCNT_W'(QDEPTH)) || (cnt_r == '0) || (wr_ptr_r != rd_ptr_r)))
    else $error("queue fill count out of step with pointers");

endmodule

@@ rtl/ndtp_back.sv @@
// ----------------------------------------------------------------------------
// ndtp_back - date builder
// Maps the three numbers to day, month and year, applies the century pivot,
// checks ranges and month length and packs the 32-bit date. Three stages:
// select and range check, year / 100 product, leap test and packing.
// ----------------------------------------------------------------------------
module ndtp_back
  import ndtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_valid,
  input  rec_t               rec,
  output logic               rec_pop,
  input  logic [ORDER_W-1:0] field_order,
  input  logic [PIVOT_W-1:0] century_pivot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_date_valid,
  output logic [DATE_W-1:0]  out_packed_date
);

  // stage 1 registers
  logic              s1_valid_r;
  logic              s1_ok_r;
  logic [DAY_W-1:0]  s1_day_r;
  logic [MON_W-1:0]  s1_month_r;
  logic [YEAR_W-1:0] s1_year_r;
  // stage 2 registers
  logic              s2_valid_r;
  logic              s2_ok_r;
  logic [DAY_W-1:0]  s2_day_r;
  logic [MON_W-1:0]  s2_month_r;
  logic [YEAR_W-1:0] s2_year_r;
  logic [PROD_W-1:0] s2_prod_r;
  // output registers
  logic              out_valid_r;
  logic              out_date_valid_r;
  logic [DATE_W-1:0] out_packed_r;

  logic              out_free, s2_adv, s1_adv;
  logic              s1_ok_nxt;
  logic [NUM_W-1:0]  sel_day, sel_month, sel_year, year_adj;
  logic              order_ok;
  logic [QUOT_W-1:0] quot;
  logic [YEAR_W-1:0] quot100, rem100;
  logic              leap;
  logic [DAY_W-1:0]  days_in_month;
  logic              date_ok;
  logic [DATE_W-1:0] packed_nxt;

  // month length with leap February
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] month,
                                                  input logic             lp);
    case (month)
      4'd2:                         month_days = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      month_days = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                 month_days = 5'd31;
      default:                      month_days = 5'd0;
    endcase
  endfunction

  // pipeline advance
  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = !s2_valid_r || out_free;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign rec_pop  = rec_valid && s1_adv;

  // stage 1: field selection, pivot and range checks
  always_comb begin
    order_ok  = 1'b1;
    sel_day   = rec.n1;
    sel_month = rec.n2;
    sel_year  = rec.n3;
    case (field_order)
      ORD_DMY: begin
        sel_day   = rec.n1;
        sel_month = rec.n2;
        sel_year  = rec.n3;
      end
      ORD_MDY: begin
        sel_day   = rec.n2;
        sel_month = rec.n1;
        sel_year  = rec.n3;
      end
      ORD_YMD: begin
        sel_day   = rec.n3;
        sel_month = rec.n2;
        sel_year  = rec.n1;
      end
      default: order_ok = 1'b0;
    endcase

    if (sel_year < TWO_DIGIT_LIMIT)
      year_adj = sel_year + ((sel_year >= NUM_W'(century_pivot)) ? CENTURY_19 : CENTURY_20);
    else
      year_adj = sel_year;

    s1_ok_nxt = rec.ok && (rec.n1 != '0) && (rec.n2 != '0) && order_ok &&
                (sel_day != '0) && (sel_day <= DAY_MAX) &&
                (sel_month != '0) && (sel_month <= MONTH_MAX) &&
                !year_adj[NUM_W-1];
  end

  // stage 3: leap year from year / 100, month length and packing
  always_comb begin
    quot    = s2_prod_r[PROD_W-1:DIV100_SHIFT];
    quot100 = (YEAR_W'(quot) << 6) + (YEAR_W'(quot) << 5) + (YEAR_W'(quot) << 2);
    rem100  = s2_year_r - quot100;
    leap    = (s2_year_r[1:0] == 2'b00) && ((rem100 != '0) || (quot[1:0] == 2'b00));
    days_in_month = month_days(s2_month_r, leap);
    date_ok = s2_ok_r && (s2_day_r <= days_in_month);
    if (date_ok)
      packed_nxt = {1'b1, 3'b000, s2_year_r, s2_month_r, s2_day_r, 2'b00,
                    (s2_year_r != '0), (s2_month_r != '0), (s2_day_r != '0)};
    else
      packed_nxt = '0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv)   s1_valid_r  <= rec_valid;
      if (s2_adv)   s2_valid_r  <= s1_valid_r;
      if (out_free) out_valid_r <= s2_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_ok_r    <= s1_ok_nxt;
      s1_day_r   <= sel_day[DAY_W-1:0];
      s1_month_r <= sel_month[MON_W-1:0];
      s1_year_r  <= year_adj[YEAR_W-1:0];
    end
    if (s2_adv) begin
      s2_ok_r    <= s1_ok_r;
      s2_day_r   <= s1_day_r;
      s2_month_r <= s1_month_r;
      s2_year_r  <= s1_year_r;
      s2_prod_r  <= PROD_W'(s1_year_r) * PROD_W'(DIV100_MUL);
    end
    if (out_free) begin
      out_date_valid_r <= date_ok;
      out_packed_r     <= packed_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_date_valid  = out_date_valid_r;
  assign out_packed_date = out_packed_r;

  // flag and packed word agree
  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_date_valid_r == (out_packed_r != '0)))
    else $error("date_valid disagrees with packed_date");

  // a valid date carries a real month and day
  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_date_valid_r) |->
      (out_packed_r[13:10] != 4'd0) && (out_packed_r[13:10] <= 4'd12) &&
      (out_packed_r[9:5] != 5'd0) && out_packed_r[DATE_W-1])
    else $error("valid date with month or day out of range");

endmodule
